// File: hdl/tmbp_pkg.sv
package tmbp_pkg;

    localparam int INDEX_BITS_DEF = 24;

    // parser phases
    localparam logic [4:0] P_GROUP  = 5'd0;
    localparam logic [4:0] P_NVERT  = 5'd1;
    localparam logic [4:0] P_KC     = 5'd2;
    localparam logic [4:0] P_HASV   = 5'd3;
    localparam logic [4:0] P_VX     = 5'd4;
    localparam logic [4:0] P_VY     = 5'd5;
    localparam logic [4:0] P_VZ     = 5'd6;
    localparam logic [4:0] P_FLAGS  = 5'd7;
    localparam logic [4:0] P_HASN   = 5'd8;
    localparam logic [4:0] P_NORM   = 5'd9;
    localparam logic [4:0] P_SPHERE = 5'd10;
    localparam logic [4:0] P_HASC   = 5'd11;
    localparam logic [4:0] P_COL    = 5'd12;
    localparam logic [4:0] P_UV     = 5'd13;
    localparam logic [4:0] P_CONS   = 5'd14;
    localparam logic [4:0] P_NTRI   = 5'd15;
    localparam logic [4:0] P_NPTS   = 5'd16;
    localparam logic [4:0] P_HAST   = 5'd17;
    localparam logic [4:0] P_TA     = 5'd18;
    localparam logic [4:0] P_TB     = 5'd19;
    localparam logic [4:0] P_TC     = 5'd20;

    // result kinds
    localparam logic [1:0] K_VERTEX = 2'd0;
    localparam logic [1:0] K_TRI    = 2'd1;
    localparam logic [1:0] K_DONE   = 2'd2;
    localparam logic [1:0] K_ERROR  = 2'd3;

    // error codes
    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_TRUNC     = 3'd1;
    localparam logic [2:0] E_NOVERT    = 3'd2;
    localparam logic [2:0] E_NONFINITE = 3'd3;
    localparam logic [2:0] E_TRIHDR    = 3'd4;
    localparam logic [2:0] E_RANGE     = 3'd5;
    localparam logic [2:0] E_BASE      = 3'd6;

    localparam logic [15:0] FLAG_TANGENTS = 16'h1000;
    localparam logic [15:0] FLAG_UV       = 16'h0001;

    // one result item, tdata packing order low to high
    typedef struct packed {
        logic        last;
        logic [2:0]  error_code;
        logic [15:0] triangle_count;
        logic [15:0] vertex_count;
        logic [23:0] index_c;
        logic [23:0] index_b;
        logic [23:0] index_a;
        logic [31:0] z_bits;
        logic [31:0] y_bits;
        logic [31:0] x_bits;
        logic [1:0]  kind;
    } t_result;

    // up to two results per byte
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_pair;

    function automatic t_result f_blank();
        t_result r;
        r = '0;
        return r;
    endfunction

endpackage

// File: hdl/tmbp_outq.sv
// Two-entry output queue: absorbs up to two results per byte, drains one per cycle while i_ready is high.
module tmbp_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tmbp_pkg::t_pair  i_pair,
    output logic             o_room,
    output logic             o_valid,
    output tmbp_pkg::t_result o_data,
    input  logic             i_ready
);
    tmbp_pkg::t_result r_q0, r_q1, n_q0, n_q1;
    logic [1:0] r_cnt, n_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q0;
    // accept a byte only if both slots are free after this cycle's pop
    assign o_room  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);

    always_comb begin
        logic pop;
        logic [1:0] c;
        pop  = o_valid && i_ready;
        n_q0 = r_q0;
        n_q1 = r_q1;
        c    = r_cnt;
        if (pop) begin
            n_q0 = r_q1;
            c    = c - 2'd1;
        end
        if (i_push) begin
            if (i_pair.v0 && i_pair.v1) begin
                n_q0 = i_pair.r0;
                n_q1 = i_pair.r1;
                c    = 2'd2;
            end else if (i_pair.v0 || i_pair.v1) begin
                n_q0 = i_pair.v0 ? i_pair.r0 : i_pair.r1;
                c    = 2'd1;
            end
        end
        n_cnt = c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end
endmodule

// File: hdl/triangle_mesh_block_parser_core.sv
// Triangle mesh block parser.
// Slave channel: one block byte per transfer in s_axis_tdata, s_axis_tlast on
// the block's final byte. Master channel: one result per transfer; tdata
// carries kind, vertex words, corner indices, counts and error code, tlast
// marks the done status or error that closes a block.
// Each byte is parsed in the cycle it is accepted; its results (at most two)
// enter a two-entry output queue and the first is visible the next cycle.
// Throughput: one byte per cycle while results are taken as fast as they
// appear; after a byte giving two results, tready stays low until one drains.
// s_axis_tready is high when the output queue can hold two more results.
// Triangle corners are offset by a running base vertex that advances only
// on a block that completes cleanly; it persists across blocks.
// Reset (synchronous, active low) returns to idle, clears the base vertex
// and empties the queue. A stalled receiver holds results in the queue and
// then deasserts s_axis_tready; nothing is dropped.
module triangle_mesh_block_parser_core #(
    parameter int INDEX_BITS = tmbp_pkg::INDEX_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tlast,   // block_last
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // kind[1:0], x_bits, y_bits, z_bits, index_a, index_b, index_c,
    // vertex_count, triangle_count, error_code[2:0], 43 zero bits
    output logic [247:0] m_axis_tdata,
    output logic         m_axis_tlast    // last
);
    localparam logic [INDEX_BITS:0] IDX_MAX = {1'b0, {INDEX_BITS{1'b1}}};

    logic [4:0]  r_phase, n_phase;
    logic [1:0]  r_bif, n_bif;
    logic [31:0] r_shift, n_shift;
    logic [2:0]  r_hskip, n_hskip;
    logic [15:0] r_vtot, n_vtot;
    logic [15:0] r_flags, n_flags;
    logic [21:0] r_skip, n_skip;
    logic [31:0] r_hx, n_hx, r_hy, n_hy;
    logic [15:0] r_loop, n_loop, r_ttot, n_ttot, r_ca, n_ca, r_cb, n_cb;
    logic [INDEX_BITS-1:0] r_base, n_base;
    logic        r_disc, n_disc;

    logic            acc, room;
    tmbp_pkg::t_pair pair;
    tmbp_pkg::t_result qd;

    assign s_axis_tready = room;
    assign acc = s_axis_tvalid && room;

    // byte field lengths per phase; zero marks counted skip phases
    function automatic logic [2:0] f_len(input logic [4:0] p);
        logic [2:0] l;
        unique case (p)
            tmbp_pkg::P_GROUP, tmbp_pkg::P_VX, tmbp_pkg::P_VY,
            tmbp_pkg::P_VZ, tmbp_pkg::P_NPTS: l = 3'd4;
            tmbp_pkg::P_NVERT, tmbp_pkg::P_KC, tmbp_pkg::P_FLAGS,
            tmbp_pkg::P_NTRI, tmbp_pkg::P_TA, tmbp_pkg::P_TB,
            tmbp_pkg::P_TC: l = 3'd2;
            tmbp_pkg::P_HASV, tmbp_pkg::P_HASN, tmbp_pkg::P_HASC,
            tmbp_pkg::P_HAST: l = 3'd1;
            default: l = 3'd0;
        endcase
        return l;
    endfunction

    function automatic logic f_nonfin(input logic [31:0] w);
        return &w[30:23];
    endfunction

    // per-byte parse
    always_comb begin
        logic [7:0]  b;
        logic [4:0]  ph;
        logic [31:0] v;
        logic [2:0]  len, err;
        logic        ended, blast, done_f;
        logic [15:0] lp1;
        logic [INDEX_BITS:0] bsum;
        logic [21:0] vt22;
        logic [1:0]  nb;
        b = s_axis_tdata;
        blast = s_axis_tlast;
        n_phase = r_phase; n_bif = r_bif; n_shift = r_shift; n_hskip = r_hskip;
        n_vtot = r_vtot; n_flags = r_flags; n_skip = r_skip; n_hx = r_hx;
        n_hy = r_hy; n_loop = r_loop; n_ttot = r_ttot; n_ca = r_ca; n_cb = r_cb;
        n_base = r_base; n_disc = r_disc;
        pair = '0;
        pair.r0 = tmbp_pkg::f_blank();
        pair.r1 = tmbp_pkg::f_blank();
        ended = 1'b0;
        err = tmbp_pkg::E_NONE;
        ph = (r_phase > tmbp_pkg::P_TC) ? tmbp_pkg::P_GROUP : r_phase;
        len = f_len(ph);
        v = r_shift | ({24'd0, b} << {r_bif, 3'b000});
        lp1 = r_loop + 16'd1;
        bsum = {1'b0, r_base} + {{(INDEX_BITS-15){1'b0}}, r_vtot};
        vt22 = {6'd0, r_vtot};
        nb = r_bif + 2'd1;
        done_f = ({1'b0, nb} == len) || (nb == 2'd0);
        if (!acc) begin
            // no transfer
        end else if (r_disc) begin
            if (blast) begin
                n_phase = tmbp_pkg::P_GROUP; n_bif = '0; n_shift = '0; n_disc = 1'b0;
            end
        end else begin
            n_phase = ph;
            if (len != 3'd0) begin
                n_shift = v;
                n_bif = nb;
                if (done_f) begin
                    n_shift = '0;
                    n_bif = '0;
                    unique case (ph)
                        tmbp_pkg::P_GROUP: n_phase = tmbp_pkg::P_NVERT;
                        tmbp_pkg::P_NVERT: begin
                            n_vtot = v[15:0]; n_phase = tmbp_pkg::P_KC;
                        end
                        tmbp_pkg::P_KC: n_phase = tmbp_pkg::P_HASV;
                        tmbp_pkg::P_HASV: begin
                            if (r_vtot == 16'd0 || v[7:0] == 8'd0)
                                err = tmbp_pkg::E_NOVERT;
                            else if (bsum > IDX_MAX)
                                err = tmbp_pkg::E_BASE;
                            else begin
                                n_loop = '0; n_phase = tmbp_pkg::P_VX;
                            end
                        end
                        tmbp_pkg::P_VX: begin n_hx = v; n_phase = tmbp_pkg::P_VY; end
                        tmbp_pkg::P_VY: begin n_hy = v; n_phase = tmbp_pkg::P_VZ; end
                        tmbp_pkg::P_VZ: begin
                            if (f_nonfin(r_hx) || f_nonfin(r_hy) || f_nonfin(v))
                                err = tmbp_pkg::E_NONFINITE;
                            else begin
                                pair.v0 = 1'b1;
                                pair.r0.kind = tmbp_pkg::K_VERTEX;
                                pair.r0.x_bits = r_hx;
                                pair.r0.y_bits = r_hy;
                                pair.r0.z_bits = v;
                                n_loop = lp1;
                                n_phase = (lp1 == r_vtot) ? tmbp_pkg::P_FLAGS
                                                          : tmbp_pkg::P_VX;
                            end
                        end
                        tmbp_pkg::P_FLAGS: begin
                            n_flags = v[15:0]; n_phase = tmbp_pkg::P_HASN;
                        end
                        tmbp_pkg::P_HASN: begin
                            if (v[7:0] != 8'd0) begin
                                n_skip = ((r_flags & tmbp_pkg::FLAG_TANGENTS) != 16'd0)
                                    ? (vt22 << 5) + (vt22 << 2)
                                    : (vt22 << 3) + (vt22 << 2);
                                n_phase = tmbp_pkg::P_NORM;
                            end else begin
                                n_skip = 22'd16; n_phase = tmbp_pkg::P_SPHERE;
                            end
                        end
                        tmbp_pkg::P_HASC: begin
                            if (v[7:0] != 8'd0) begin
                                n_skip = vt22 << 4; n_phase = tmbp_pkg::P_COL;
                            end else if ((r_flags & tmbp_pkg::FLAG_UV) != 16'd0) begin
                                n_skip = vt22 << 3; n_phase = tmbp_pkg::P_UV;
                            end else begin
                                n_phase = tmbp_pkg::P_CONS; n_hskip = 3'd6;
                            end
                        end
                        tmbp_pkg::P_NTRI: begin
                            n_ttot = v[15:0]; n_phase = tmbp_pkg::P_NPTS;
                        end
                        tmbp_pkg::P_NPTS: begin
                            n_hx = (v == ({16'd0, r_ttot} << 1) + {16'd0, r_ttot})
                                   ? 32'd1 : 32'd0;
                            n_phase = tmbp_pkg::P_HAST;
                        end
                        tmbp_pkg::P_HAST: begin
                            if (v[7:0] == 8'd0 || r_ttot == 16'd0 || r_hx == 32'd0)
                                err = tmbp_pkg::E_TRIHDR;
                            else begin
                                n_loop = '0; n_phase = tmbp_pkg::P_TA;
                            end
                        end
                        tmbp_pkg::P_TA: begin n_ca = v[15:0]; n_phase = tmbp_pkg::P_TB; end
                        tmbp_pkg::P_TB: begin n_cb = v[15:0]; n_phase = tmbp_pkg::P_TC; end
                        default: begin
                            if (r_ca >= r_vtot || r_cb >= r_vtot || v[15:0] >= r_vtot)
                                err = tmbp_pkg::E_RANGE;
                            else begin
                                pair.v0 = 1'b1;
                                pair.r0.kind = tmbp_pkg::K_TRI;
                                pair.r0.index_a = 24'(r_base + INDEX_BITS'(r_ca));
                                pair.r0.index_b = 24'(r_base + INDEX_BITS'(r_cb));
                                pair.r0.index_c = 24'(r_base + INDEX_BITS'(v[15:0]));
                                n_loop = lp1;
                                if (lp1 == r_ttot) begin
                                    pair.v1 = 1'b1;
                                    pair.r1.kind = tmbp_pkg::K_DONE;
                                    pair.r1.vertex_count = r_vtot;
                                    pair.r1.triangle_count = r_ttot;
                                    pair.r1.last = 1'b1;
                                    n_base = bsum[INDEX_BITS-1:0];
                                    ended = 1'b1;
                                end else begin
                                    n_phase = tmbp_pkg::P_TA;
                                end
                            end
                        end
                    endcase
                end
            end else if (ph == tmbp_pkg::P_CONS) begin
                if (r_hskip != 3'd0) n_hskip = r_hskip - 3'd1;
                if (r_hskip <= 3'd1) n_phase = tmbp_pkg::P_NTRI;
            end else begin
                if (r_skip != 22'd0) n_skip = r_skip - 22'd1;
                if (r_skip <= 22'd1) begin
                    priority case (ph)
                        tmbp_pkg::P_NORM: begin
                            n_skip = 22'd16; n_phase = tmbp_pkg::P_SPHERE;
                        end
                        tmbp_pkg::P_SPHERE: n_phase = tmbp_pkg::P_HASC;
                        tmbp_pkg::P_COL: begin
                            if ((r_flags & tmbp_pkg::FLAG_UV) != 16'd0) begin
                                n_skip = vt22 << 3; n_phase = tmbp_pkg::P_UV;
                            end else begin
                                n_phase = tmbp_pkg::P_CONS; n_hskip = 3'd6;
                            end
                        end
                        default: begin
                            n_phase = tmbp_pkg::P_CONS; n_hskip = 3'd6;
                        end
                    endcase
                end
            end
            // error or truncation result goes in the next free slot
            if (err != tmbp_pkg::E_NONE || (blast && !ended)) begin
                if (pair.v0) begin
                    pair.v1 = 1'b1;
                    pair.r1.kind = tmbp_pkg::K_ERROR;
                    pair.r1.error_code = (err != tmbp_pkg::E_NONE) ? err : tmbp_pkg::E_TRUNC;
                    pair.r1.last = 1'b1;
                end else begin
                    pair.v0 = 1'b1;
                    pair.r0.kind = tmbp_pkg::K_ERROR;
                    pair.r0.error_code = (err != tmbp_pkg::E_NONE) ? err : tmbp_pkg::E_TRUNC;
                    pair.r0.last = 1'b1;
                end
                if (err != tmbp_pkg::E_NONE) ended = 1'b1;
            end
            if (blast) begin
                n_phase = tmbp_pkg::P_GROUP; n_bif = '0; n_shift = '0; n_disc = 1'b0;
            end else if (ended) begin
                n_phase = tmbp_pkg::P_GROUP; n_bif = '0; n_shift = '0; n_disc = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tmbp_pkg::P_GROUP; r_bif <= '0; r_shift <= '0; r_hskip <= '0;
            r_vtot <= '0; r_flags <= '0; r_skip <= '0; r_hx <= '0; r_hy <= '0;
            r_loop <= '0; r_ttot <= '0; r_ca <= '0; r_cb <= '0; r_base <= '0;
            r_disc <= 1'b0;
        end else begin
            r_phase <= n_phase; r_bif <= n_bif; r_shift <= n_shift; r_hskip <= n_hskip;
            r_vtot <= n_vtot; r_flags <= n_flags; r_skip <= n_skip; r_hx <= n_hx;
            r_hy <= n_hy; r_loop <= n_loop; r_ttot <= n_ttot; r_ca <= n_ca;
            r_cb <= n_cb; r_base <= n_base; r_disc <= n_disc;
        end
    end

    tmbp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (acc),
        .i_pair  (pair),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .o_data  (qd),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {43'd0, qd.error_code, qd.triangle_count, qd.vertex_count,
                           qd.index_c, qd.index_b, qd.index_a, qd.z_bits, qd.y_bits,
                           qd.x_bits, qd.kind};
    assign m_axis_tlast = qd.last;

`ifndef SYNTH
    // a result marked last is always a status or an error
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1]) else $error("last on data");
    // a block's final byte always leaves the parser idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=>
        r_phase == tmbp_pkg::P_GROUP && !r_disc) else $error("not idle after last");
    // base never moves without an accepted transfer; the design moves it only on one completing a block
    a_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tvalid && s_axis_tready) |=> $stable(r_base)) else $error("base moved");
`endif
endmodule
